### src/esfc_pkg.sv
// esfc_pkg: widths, fixed-point constants and fit coefficients of the erfc-log filter
// no dependencies; imported by esfc_log2, esfc_sqrt, esfc_pow, esfc_poly and the top level
package esfc_pkg;

  localparam int IDX_W      = 10;
  localparam int ORDER_W    = 7;
  localparam int ATTN_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {REG_TOP, REG_LAG, REG_ORDER, REG_ATTN} reg_idx_t;

  // squared integers and their log2 in q24
  localparam int SQ_W       = 20;
  localparam int LOG_ROUNDS = 24;
  localparam int LOG_LAT    = LOG_ROUNDS + 1;
  localparam int LOG_W      = 5 + LOG_ROUNDS;

  // q30 quantities up to one
  localparam int Q_W        = 31;
  localparam int DIV_QW     = 31;

  localparam int Z2_W       = 36;
  localparam int Z_W        = 30;
  localparam int SQRT_STEPS = (Z2_W + 24) / 2;
  localparam int DEN_W      = 36;

  localparam int POLY_W     = 33;
  localparam int POLY_LAT   = 5;
  localparam int W_W        = 49;

  localparam logic [Q_W-1:0] Q30_ONE = 31'h4000_0000;
  localparam logic [29:0]    LN2_Q30 = 30'd744261118;
  localparam logic [28:0]    FIT_P   = 29'd351748265;

  localparam logic signed [POLY_W-1:0] FIT_A1 = 33'sd273621191;
  localparam logic signed [POLY_W-1:0] FIT_A2 = -33'sd305476044;
  localparam logic signed [POLY_W-1:0] FIT_A3 = 33'sd1526231383;
  localparam logic signed [POLY_W-1:0] FIT_A4 = -33'sd1560310108;
  localparam logic signed [POLY_W-1:0] FIT_A5 = 33'sd1139675401;

endpackage

### src/esfc_log2.sv
// esfc_log2: pipelined log2 of a positive integer in q24, one squaring round per stage
// depends on esfc_pkg
module esfc_log2 import esfc_pkg::*; (
  input  logic             clk,
  input  logic [SQ_W-1:0]  x,
  output logic [LOG_W-1:0] lg
);

  localparam int M_W = 31;
  localparam int N_W = 5;

  logic [N_W-1:0]        n_comb;
  logic [M_W-1:0]        m_comb;
  logic [N_W-1:0]        n_q    [LOG_LAT];
  logic [M_W-1:0]        m_q    [LOG_LAT];
  logic [LOG_ROUNDS-1:0] frac_q [LOG_LAT];
  logic [2*M_W-1:0]      sq     [LOG_ROUNDS];

  // leading one and normalisation to a q30 mantissa in [1, 2)
  always_comb begin
    n_comb = '0;
    for (int k = 1; k < SQ_W; k++) begin
      if (x[k]) begin
        n_comb = N_W'(k);
      end
    end
    m_comb = M_W'(x) << (N_W'(30) - n_comb);
  end

  always_comb begin
    for (int j = 0; j < LOG_ROUNDS; j++) begin
      sq[j] = (2*M_W)'(m_q[j]) * (2*M_W)'(m_q[j]);
    end
  end

  always_ff @(posedge clk) begin
    n_q[0]    <= n_comb;
    m_q[0]    <= m_comb;
    frac_q[0] <= '0;
    for (int j = 0; j < LOG_ROUNDS; j++) begin
      n_q[j+1] <= n_q[j];
      if (sq[j][2*M_W-1]) begin
        m_q[j+1]    <= sq[j][2*M_W-1 -: M_W];
        frac_q[j+1] <= {frac_q[j][LOG_ROUNDS-2:0], 1'b1};
      end else begin
        m_q[j+1]    <= sq[j][2*M_W-2 -: M_W];
        frac_q[j+1] <= {frac_q[j][LOG_ROUNDS-2:0], 1'b0};
      end
    end
  end

  assign lg = {n_q[LOG_ROUNDS], frac_q[LOG_ROUNDS]};

endmodule

### src/esfc_div.sv
// esfc_div: pipelined restoring divider, one quotient bit per stage
// no dependencies; quotient must fit QUO_W bits
module esfc_div #(
  parameter int NUM_W = 50,
  parameter int DIV_W = 20,
  parameter int QUO_W = 31
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DIV_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  localparam int CW = (NUM_W > DIV_W + QUO_W) ? NUM_W : DIV_W + QUO_W;

  logic [CW-1:0]    rem_q  [QUO_W];
  logic [DIV_W-1:0] den_q  [QUO_W];
  logic [QUO_W-1:0] quo_q  [QUO_W];
  logic [CW-1:0]    rem_in [QUO_W];
  logic [DIV_W-1:0] den_in [QUO_W];
  logic [QUO_W-1:0] quo_in [QUO_W];
  logic [CW-1:0]    dsh    [QUO_W];
  logic             ge     [QUO_W];

  always_comb begin
    rem_in[0] = CW'(num);
    den_in[0] = den;
    quo_in[0] = '0;
    for (int j = 1; j < QUO_W; j++) begin
      rem_in[j] = rem_q[j-1];
      den_in[j] = den_q[j-1];
      quo_in[j] = quo_q[j-1];
    end
    for (int j = 0; j < QUO_W; j++) begin
      dsh[j] = CW'(den_in[j]) << (QUO_W - 1 - j);
      ge[j]  = rem_in[j] >= dsh[j];
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < QUO_W; j++) begin
      rem_q[j] <= ge[j] ? rem_in[j] - dsh[j] : rem_in[j];
      den_q[j] <= den_in[j];
      quo_q[j] <= {quo_in[j][QUO_W-2:0], ge[j]};
    end
  end

  assign quo = quo_q[QUO_W-1];

endmodule

### src/esfc_sqrt.sv
// esfc_sqrt: pipelined integer square root of z2 scaled by 2^24, one result bit per stage
// depends on esfc_pkg
module esfc_sqrt import esfc_pkg::*; (
  input  logic            clk,
  input  logic [Z2_W-1:0] z2,
  output logic [Z_W-1:0]  z
);

  localparam int V_W = Z2_W + 24;

  logic [V_W-1:0] v_q    [SQRT_STEPS];
  logic [V_W-1:0] res_q  [SQRT_STEPS];
  logic [V_W-1:0] v_in   [SQRT_STEPS];
  logic [V_W-1:0] res_in [SQRT_STEPS];
  logic [V_W:0]   bitv   [SQRT_STEPS];
  logic [V_W:0]   sum    [SQRT_STEPS];
  logic           ge     [SQRT_STEPS];

  always_comb begin
    v_in[0]   = {z2, 24'b0};
    res_in[0] = '0;
    for (int j = 1; j < SQRT_STEPS; j++) begin
      v_in[j]   = v_q[j-1];
      res_in[j] = res_q[j-1];
    end
    for (int j = 0; j < SQRT_STEPS; j++) begin
      bitv[j] = (V_W+1)'(1) << (V_W - 2 - 2*j);
      sum[j]  = {1'b0, res_in[j]} + bitv[j];
      ge[j]   = {1'b0, v_in[j]} >= sum[j];
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < SQRT_STEPS; j++) begin
      if (ge[j]) begin
        v_q[j]   <= v_in[j] - sum[j][V_W-1:0];
        res_q[j] <= (res_in[j] >> 1) + bitv[j][V_W-1:0];
      end else begin
        v_q[j]   <= v_in[j];
        res_q[j] <= res_in[j] >> 1;
      end
    end
  end

  assign z = res_q[SQRT_STEPS-1][Z_W-1:0];

endmodule

### src/esfc_pow.sv
// esfc_pow: q30 power by square and multiply, one exponent bit per stage
// depends on esfc_pkg; exponent is the static filter order
module esfc_pow import esfc_pkg::*; (
  input  logic               clk,
  input  logic [Q_W-1:0]     base,
  input  logic [ORDER_W-1:0] expn,
  output logic [Q_W-1:0]     acc
);

  localparam logic [2*Q_W-1:0] HALF = (2*Q_W)'(1) << 29;

  logic [Q_W-1:0]   acc_q  [ORDER_W];
  logic [Q_W-1:0]   base_q [ORDER_W-1];
  logic [Q_W-1:0]   acc_in [ORDER_W];
  logic [Q_W-1:0]   b_in   [ORDER_W];
  logic [2*Q_W-1:0] pa     [ORDER_W];
  logic [2*Q_W-1:0] pb     [ORDER_W];

  always_comb begin
    acc_in[0] = Q30_ONE;
    b_in[0]   = base;
    for (int j = 1; j < ORDER_W; j++) begin
      acc_in[j] = acc_q[j-1];
      b_in[j]   = base_q[j-1];
    end
    for (int j = 0; j < ORDER_W; j++) begin
      pa[j] = (2*Q_W)'(acc_in[j]) * (2*Q_W)'(b_in[j]) + HALF;
      pb[j] = (2*Q_W)'(b_in[j]) * (2*Q_W)'(b_in[j]) + HALF;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < ORDER_W; j++) begin
      acc_q[j] <= expn[j] ? pa[j][30 +: Q_W] : acc_in[j];
      if (j < ORDER_W - 1) begin
        base_q[j] <= pb[j][30 +: Q_W];
      end
    end
  end

  assign acc = acc_q[ORDER_W-1];

endmodule

### src/esfc_poly.sv
// esfc_poly: five-term rational fit of erfc, horner steps in q30, one product per stage
// depends on esfc_pkg
module esfc_poly import esfc_pkg::*; (
  input  logic           clk,
  input  logic [Q_W-1:0] t,
  output logic [Q_W-1:0] r
);

  function automatic logic signed [POLY_W-1:0] mul_q30(
    input logic signed [POLY_W-1:0] a,
    input logic [Q_W-1:0]           b
  );
    logic [31:0]                mag;
    logic [31+Q_W:0]            pr;
    logic signed [POLY_W-1:0]   res;
    mag = a[POLY_W-1] ? 32'(-a) : 32'(a);
    pr  = (32+Q_W)'(mag) * (32+Q_W)'(b);
    res = signed'(pr[30 +: POLY_W]);
    return a[POLY_W-1] ? -res : res;
  endfunction

  logic signed [POLY_W-1:0] coef [POLY_LAT-1];
  logic signed [POLY_W-1:0] m_q  [POLY_LAT];
  logic [Q_W-1:0]           t_q  [POLY_LAT-1];

  assign coef[0] = FIT_A4;
  assign coef[1] = FIT_A3;
  assign coef[2] = FIT_A2;
  assign coef[3] = FIT_A1;

  always_ff @(posedge clk) begin
    m_q[0] <= mul_q30(FIT_A5, t);
    t_q[0] <= t;
    for (int j = 1; j < POLY_LAT; j++) begin
      m_q[j] <= mul_q30(coef[j-1] + m_q[j-1], t_q[j-1]);
      if (j < POLY_LAT - 1) begin
        t_q[j] <= t_q[j-1];
      end
    end
  end

  // negative fit counts as zero
  assign r = m_q[POLY_LAT-1][POLY_W-1] ? '0 : m_q[POLY_LAT-1][Q_W-1:0];

endmodule

### src/erfc_spectral_filter_coefficient.sv
// erfc_spectral_filter_coefficient: top level of the erfc-log spectral filter weight pipeline
// depends on esfc_pkg, esfc_log2, esfc_div, esfc_sqrt, esfc_pow, esfc_poly
//
// usage
// - request channel: wave_index is taken at a rising edge with start high and busy low;
//   busy is high only in the cycle after a reset cycle, so a request may come every cycle
// - result channel: done pulses for one cycle with weight (unsigned q1.WEIGHT_FRAC_BITS)
//   and index_error; results leave in request order
// - throughput is one request per cycle, fixed by the fully pipelined datapath
//   (two 25-stage log2 units, a 30-stage square root, two 31-stage dividers,
//   a 7-stage power unit and a 5-stage horner chain)
// - configuration: cfg_valid/cfg_ready write channel, cfg_index picks top_index (0),
//   lag_index (1), filter_order (2) or attenuation (3); write only with no request in flight
// - reset (rst, synchronous) restores the register defaults and drops all requests in flight
// - the receiver cannot stall: there is no back-pressure on the result side
module erfc_spectral_filter_coefficient import esfc_pkg::*; #(
  parameter int MAX_INDEX        = 1023,
  parameter int WEIGHT_FRAC_BITS = 15
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [IDX_W-1:0]            wave_index,
  output logic                        done,
  output logic [WEIGHT_FRAC_BITS:0]   weight,
  output logic                        index_error,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  typedef enum logic [1:0] {KIND_ERR, KIND_ONE, KIND_EDGE, KIND_MID} kind_t;
  typedef struct packed {
    logic  valid;
    kind_t kind;
    logic  neg;
  } tag_t;

  localparam int S_FRONT  = 1;
  localparam int S_LOG    = S_FRONT + LOG_LAT;
  localparam int S_Z2     = S_LOG + 3;
  localparam int S_Z      = S_Z2 + SQRT_STEPS;
  localparam int S_PZ     = S_Z + 1;
  localparam int S_T      = S_PZ + DIV_QW;
  localparam int S_R      = S_T + POLY_LAT;
  localparam int S_EXPO   = S_FRONT + DIV_QW + ORDER_W;
  localparam int EXPO_DLY = S_R - S_EXPO;
  localparam int S_H      = S_R + 1;
  localparam int S_W      = S_H + 1;
  localparam int SH       = 45 - WEIGHT_FRAC_BITS;
  localparam logic [WEIGHT_FRAC_BITS:0] ONE_W = (WEIGHT_FRAC_BITS+1)'(1) << WEIGHT_FRAC_BITS;

  logic [IDX_W-1:0]   top_index;
  logic [IDX_W-1:0]   lag_index;
  logic [ORDER_W-1:0] filter_order;
  logic [ATTN_W-1:0]  attenuation;

  logic               accept;
  logic [IDX_W-1:0]   top_eff;
  logic [IDX_W-1:0]   a, b, d;
  logic [SQ_W-1:0]    ab;
  kind_t              kind;
  logic               neg;

  logic [SQ_W-1:0]    dd_q, prod_q;
  tag_t               tag_q [S_W];

  logic [LOG_W-1:0]   l1, l2;
  logic [LOG_W-1:0]   diff_q;
  logic [LOG_W+29:0]  lnp;
  logic [LOG_W-1:0]   ln_q;
  logic [Z2_W-1:0]    z2_q;
  logic [Z_W-1:0]     z;
  logic [58:0]        pzp;
  logic [34:0]        pz_q;
  logic [Q_W-1:0]     t, q, expo, r;
  logic [Q_W-1:0]     expo_d [EXPO_DLY];
  logic [2*Q_W-1:0]   hp;
  logic [Q_W-1:0]     h_q;
  logic [Q_W-1:0]     f;
  logic signed [17:0] keep;
  logic [46:0]        fprod;
  logic signed [W_W-1:0] w_q;
  logic [W_W:0]       rsum;
  logic [W_W:0]       rnd;
  logic [WEIGHT_FRAC_BITS:0] wgt;
  logic               err;

  assign accept    = start && !busy;
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top_index    <= IDX_W'(1);
      lag_index    <= '0;
      filter_order <= ORDER_W'(8);
      attenuation  <= 16'h8000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_TOP:   top_index    <= cfg_data[IDX_W-1:0];
        REG_LAG:   lag_index    <= cfg_data[IDX_W-1:0];
        REG_ORDER: filter_order <= cfg_data[ORDER_W-1:0];
        REG_ATTN:  attenuation  <= cfg_data[ATTN_W-1:0];
        default:   top_index    <= top_index;
      endcase
    end
  end

  // front stage: classification and the exact squares d^2 and 4ab
  assign top_eff = (17'(top_index) > 17'(MAX_INDEX)) ? IDX_W'(MAX_INDEX) : top_index;
  assign a       = wave_index - lag_index;
  assign b       = top_eff - wave_index;
  assign d       = top_eff - lag_index;
  assign ab      = SQ_W'(a) * SQ_W'(b);
  assign neg     = {a, 1'b0} < {1'b0, d};

  always_comb begin
    priority if (wave_index > top_eff) begin
      kind = KIND_ERR;
    end else if (lag_index >= top_eff || wave_index <= lag_index) begin
      kind = KIND_ONE;
    end else if (wave_index == top_eff) begin
      kind = KIND_EDGE;
    end else begin
      kind = KIND_MID;
    end
  end

  always_ff @(posedge clk) begin
    dd_q   <= SQ_W'(d) * SQ_W'(d);
    prod_q <= {ab[SQ_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < S_W; k++) begin
        tag_q[k] <= '0;
      end
    end else begin
      tag_q[0] <= '{valid: accept, kind: kind, neg: neg};
      for (int k = 1; k < S_W; k++) begin
        tag_q[k] <= tag_q[k-1];
      end
    end
  end

  // exponent argument z^2 from the log ratio
  esfc_log2 u_log_dd (.clk(clk), .x(dd_q),   .lg(l1));
  esfc_log2 u_log_pr (.clk(clk), .x(prod_q), .lg(l2));

  assign lnp = (LOG_W+30)'(diff_q) * (LOG_W+30)'(LN2_Q30);

  always_ff @(posedge clk) begin
    diff_q <= (l1 > l2) ? l1 - l2 : '0;
    ln_q   <= lnp[LOG_W+29:30];
    z2_q   <= Z2_W'(ln_q) * Z2_W'(filter_order);
  end

  esfc_sqrt u_sqrt (.clk(clk), .z2(z2_q), .z(z));

  assign pzp = 59'(FIT_P) * 59'(z);

  always_ff @(posedge clk) begin
    pz_q <= pzp[58:24];
  end

  esfc_div #(.NUM_W(61), .DIV_W(DEN_W), .QUO_W(DIV_QW)) u_div_t (
    .clk (clk),
    .num (61'(1) << 60),
    .den (DEN_W'(Q30_ONE) + DEN_W'(pz_q)),
    .quo (t)
  );

  esfc_poly u_poly (.clk(clk), .t(t), .r(r));

  // exp(-z^2) as (4ab/d^2)^order
  esfc_div #(.NUM_W(SQ_W+30), .DIV_W(SQ_W), .QUO_W(DIV_QW)) u_div_q (
    .clk (clk),
    .num ({prod_q, 30'b0}),
    .den (dd_q),
    .quo (q)
  );

  esfc_pow u_pow (.clk(clk), .base(q), .expn(filter_order), .acc(expo));

  always_ff @(posedge clk) begin
    expo_d[0] <= expo;
    for (int k = 1; k < EXPO_DLY; k++) begin
      expo_d[k] <= expo_d[k-1];
    end
  end

  // half erfc, side selection and blend with the attenuation
  assign hp = (2*Q_W)'(r) * (2*Q_W)'(expo_d[EXPO_DLY-1]);

  always_ff @(posedge clk) begin
    h_q <= (hp[31 +: Q_W] > Q30_ONE) ? Q30_ONE : hp[31 +: Q_W];
  end

  always_comb begin
    if (tag_q[S_H-1].kind == KIND_EDGE) begin
      f = '0;
    end else if (tag_q[S_H-1].neg) begin
      f = Q30_ONE - h_q;
    end else begin
      f = h_q;
    end
    keep  = 18'sd32768 - signed'({2'b00, attenuation});
    fprod = 47'(attenuation) * 47'(f);
  end

  always_ff @(posedge clk) begin
    w_q <= (W_W'(keep) <<< 30) + signed'(W_W'(fprod));
  end

  always_comb begin
    rsum = (W_W+1)'(w_q) + ((W_W+1)'(1) << (SH - 1));
    rnd  = rsum >> SH;
    err  = 1'b0;
    unique case (tag_q[S_W-1].kind)
      KIND_ERR: begin
        wgt = '0;
        err = 1'b1;
      end
      KIND_ONE: begin
        wgt = ONE_W;
      end
      KIND_EDGE, KIND_MID: begin
        if (w_q <= 0) begin
          wgt = '0;
        end else if (rnd > (W_W+1)'(ONE_W)) begin
          wgt = ONE_W;
        end else begin
          wgt = rnd[WEIGHT_FRAC_BITS:0];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tag_q[S_W-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    weight      <= wgt;
    index_error <= err;
  end

endmodule

### src/esfc_checker.sv
// esfc_checker: port-level assertions for the filter weight block
// bound to erfc_spectral_filter_coefficient; no other dependencies
module esfc_checker #(
  parameter int WFB = 15,
  parameter int LAT = 99
) (
  input logic         clk,
  input logic         rst,
  input logic         start,
  input logic         busy,
  input logic         done,
  input logic [WFB:0] weight,
  input logic         index_error,
  input logic         cfg_ready
);

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && index_error |-> weight == '0)
    else $error("flagged index with nonzero weight");

  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    done |-> weight <= ((WFB+1)'(1) << WFB))
    else $error("weight above one");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without a request at fixed latency");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> !busy && cfg_ready)
    else $error("block not ready outside reset");

endmodule

bind erfc_spectral_filter_coefficient esfc_checker #(.WFB(WEIGHT_FRAC_BITS)) u_esfc_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .weight      (weight),
  .index_error (index_error),
  .cfg_ready   (cfg_ready)
);

### tb/erfc_spectral_filter_coefficient_tb.sv
// erfc_spectral_filter_coefficient_tb: self-checking bench for the erfc-log filter weight block
// recomputes each weight in integer fixed point and checks every result in order
// depends on esfc_pkg and erfc_spectral_filter_coefficient
`timescale 1ns / 100ps

module erfc_spectral_filter_coefficient_tb;
  import esfc_pkg::*;

  localparam longint unsigned ONE_Q30 = 64'd1 << 30;
  localparam longint unsigned WEIGHT_ONE = 64'd1 << 15;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [15:0] weight;
    logic        index_error;
  } weight_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [IDX_W-1:0] wave_index = '0;
  logic done;
  logic [15:0] weight;
  logic index_error;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  longint unsigned top_reg, lag_reg, order_reg, attn_reg;
  weight_t weight_q[$];
  int errors = 0;
  int requests = 0;
  int results = 0;
  int config_writes = 0;
  int cycles = 0;

  erfc_spectral_filter_coefficient dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .wave_index(wave_index),
    .done(done), .weight(weight), .index_error(index_error),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic longint unsigned log2_fix(longint unsigned x);
    longint unsigned n, m, frac;
    n = 0;
    frac = 0;
    if (x == 0) return 0;
    while (n < 30 && (x >> n) > 1) n++;
    m = x << (30 - n);
    for (int k = 0; k < 24; k++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return (n << 24) | frac;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint signed scale_q30(longint signed a, longint unsigned t);
    longint unsigned mag, pr;
    mag = (a < 0) ? longint'(-a) : longint'(a);
    pr = (mag * t) >> 30;
    return (a < 0) ? -longint'(pr) : longint'(pr);
  endfunction

  function automatic longint unsigned power_q30(longint unsigned base, longint unsigned e);
    longint unsigned acc;
    acc = ONE_Q30;
    while (e != 0) begin
      if (e[0]) acc = (acc * base + (ONE_Q30 >> 1)) >> 30;
      base = (base * base + (ONE_Q30 >> 1)) >> 30;
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic longint unsigned half_erfc(longint unsigned z2, longint unsigned expo);
    longint unsigned z, den, t;
    longint signed poly, r;
    z = int_sqrt(z2 << 24);
    den = ONE_Q30 + ((64'(FIT_P) * z) >> 24);
    t = (64'd1 << 60) / den;
    poly = 64'(FIT_A5);
    poly = 64'(FIT_A4) + scale_q30(poly, t);
    poly = 64'(FIT_A3) + scale_q30(poly, t);
    poly = 64'(FIT_A2) + scale_q30(poly, t);
    poly = 64'(FIT_A1) + scale_q30(poly, t);
    r = scale_q30(poly, t);
    if (r < 0) r = 0;
    return ((longint'(r) * expo) >> 30) >> 1;
  endfunction

  function automatic longint unsigned blend_weight(longint unsigned attn, longint unsigned f);
    longint signed w;
    longint unsigned r;
    w = (longint'(32768) - longint'(attn)) * longint'(ONE_Q30) + longint'(attn * f);
    if (w <= 0) return 0;
    r = (longint'(w) + (64'd1 << 29)) >> 30;
    return (r > WEIGHT_ONE) ? WEIGHT_ONE : r;
  endfunction

  function automatic weight_t predict_weight(longint unsigned idx);
    weight_t res;
    longint unsigned a, b, d, dd, prod, l1, l2, diff, z2, q, h, f;
    res = '0;
    if (idx > top_reg) begin
      res.index_error = 1'b1;
    end else if (lag_reg >= top_reg || idx <= lag_reg) begin
      res.weight = 16'(WEIGHT_ONE);
    end else if (idx == top_reg) begin
      res.weight = 16'(blend_weight(attn_reg, 0));
    end else begin
      a = idx - lag_reg;
      b = top_reg - idx;
      d = top_reg - lag_reg;
      dd = d * d;
      prod = 4 * a * b;
      l1 = log2_fix(dd);
      l2 = log2_fix(prod);
      diff = (l1 > l2) ? l1 - l2 : 0;
      z2 = ((diff * 64'(LN2_Q30)) >> 30) * order_reg;
      q = (prod << 30) / dd;
      h = half_erfc(z2, power_q30(q, order_reg));
      if (h > ONE_Q30) h = ONE_Q30;
      f = (2 * a < d) ? ONE_Q30 - h : h;
      res.weight = 16'(blend_weight(attn_reg, f));
    end
    return res;
  endfunction

  // result checker
  always @(posedge clk) begin
    weight_t exp_w;
    cycles <= cycles + 1;
    if (!rst && done) begin
      results <= results + 1;
      if (weight_q.size() == 0) begin
        $error("result with no request outstanding: weight %0d", weight);
        errors++;
      end else begin
        exp_w = weight_q.pop_front();
        if (weight !== exp_w.weight) begin
          $error("weight: expected %0d, got %0d", exp_w.weight, weight);
          errors++;
        end
        if (index_error !== exp_w.index_error) begin
          $error("index_error: expected %0d, got %0d", exp_w.index_error, index_error);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("erfc_spectral_filter_coefficient_tb: errors");
      $finish;
    end
  end

  task automatic send_index(input logic [IDX_W-1:0] idx);
    int gap;
    gap = $urandom_range(0, 17);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    wave_index <= idx;
    do @(posedge clk); while (busy);
    weight_q.push_back(predict_weight(64'(idx)));
    requests++;
  endtask

  task automatic drain;
    start <= 1'b0;
    while (weight_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input int idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_TOP: begin
        top_reg = value & 16'h3FF;
      end
      REG_LAG: begin
        lag_reg = value & 16'h3FF;
      end
      REG_ORDER: begin
        order_reg = value & 16'h7F;
      end
      default: begin
        attn_reg = value;
      end
    endcase
    config_writes++;
  endtask

  task automatic set_filter(input logic [15:0] top, input logic [15:0] lag,
                            input logic [15:0] order, input logic [15:0] attn);
    drain();
    write_reg(REG_TOP, top);
    write_reg(REG_LAG, lag);
    write_reg(REG_ORDER, order);
    write_reg(REG_ATTN, attn);
  endtask

  task automatic test_reset_defaults;
    for (int i = 0; i < 4; i++) send_index(IDX_W'(i));
    send_index(10'h3FF);
  endtask

  task automatic test_directed;
    set_filter(16'd1023, 16'd0, 16'd64, 16'd32768);
    send_index(10'd0);
    send_index(10'd1);
    send_index(10'd511);
    send_index(10'd512);
    send_index(10'd1022);
    send_index(10'd1023);
    set_filter(16'd100, 16'd20, 16'd0, 16'd0);
    send_index(10'd20);
    send_index(10'd21);
    send_index(10'd60);
    send_index(10'd100);
    send_index(10'd101);
    set_filter(16'hFFFF, 16'd1022, 16'd127, 16'hFFFF);
    send_index(10'd1022);
    send_index(10'd1023);
    set_filter(16'd10, 16'd10, 16'd8, 16'd16384);
    send_index(10'd5);
    send_index(10'd10);
    send_index(10'd11);
    set_filter(16'd0, 16'd0, 16'd1, 16'd32768);
    send_index(10'd0);
    send_index(10'd1);
    set_filter(16'd2, 16'd0, 16'd64, 16'd32767);
    send_index(10'd1);
    send_index(10'd2);
  endtask

  task automatic test_random_tables;
    int top, lag, order, attn, burst, sel;
    int remaining;
    remaining = 800;
    while (remaining > 0) begin
      sel = $urandom_range(0, 9);
      top = (sel < 2) ? $urandom_range(1, 8) : $urandom_range(1, 1023);
      if (sel == 9) top = 0;
      lag = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, top - 1);
      if (top == 0) lag = 0;
      order = ($urandom_range(0, 7) == 0) ? $urandom_range(65, 127) : $urandom_range(0, 64);
      attn = ($urandom_range(0, 7) == 0) ? $urandom_range(32769, 65535)
                                          : $urandom_range(0, 32768);
      set_filter(16'(top), 16'(lag), 16'(order), 16'(attn));
      burst = $urandom_range(20, 60);
      for (int k = 0; k < burst && remaining > 0; k++) begin
        if ($urandom_range(0, 9) == 0) send_index(IDX_W'($urandom_range(0, 1023)));
        else send_index(IDX_W'($urandom_range(0, top)));
        remaining--;
      end
    end
  endtask

  initial begin
    top_reg = 1;
    lag_reg = 0;
    order_reg = 8;
    attn_reg = 32768;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_random_tables();
    drain();
    repeat (120) @(posedge clk);
    $display("%0d requests and %0d results checked over %0d register writes",
             requests, results, config_writes);
    $display("covered reset defaults, endpoints, out-of-range indices and random filter set-ups");
    if (errors == 0 && weight_q.size() == 0) begin
      $display("erfc_spectral_filter_coefficient_tb: clean");
    end else begin
      $display("erfc_spectral_filter_coefficient_tb: errors");
    end
    $finish;
  end

endmodule
